// ===== src/swm_pkg.sv =====
// Shared types and constants for the sliding window minimum block.
`default_nettype none
package swm_pkg;

  localparam int ValueW = 32;
  localparam int SlotW  = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OM_PTR,
    ST_OM_VAL,
    ST_SCAN,
    ST_RESOLVE,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic om_ptr;
    logic om_val;
    logic scan;
    logic resolve;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic filled;
    logic last_slot;
    logic hit_old;
    logic scan_done;
    logic out_full;
  } status_t;

endpackage
`default_nettype wire

// ===== src/swm_if.sv =====
// Request channel interfaces: input value and window minimum result.
`default_nettype none
interface swm_in_if import swm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] min_value;
  logic [SlotW-1:0]  min_slot;
  logic              first_return;

  modport source(output valid, output min_value, output min_slot, output first_return,
                 input ready);
  modport sink(input valid, input min_value, input min_slot, input first_return,
               output ready);
endinterface
`default_nettype wire

// ===== src/sliding_window_minimum.sv =====
// Sliding window minimum over the last WINDOW values, two-stack ring queue.
//
// sample channel carries one 32-bit value per request; result channel carries
// the window minimum, its ring slot (6 bits) and a first-return flag.
// After reset the ring is empty: the first WINDOW-1 requests only fill it,
// back to back, and give no result. Every later request gives one result.
// Steps per request:
//   in the usual case accept, select, load result register;
//   when the oldest-stack minimum leaves the window, a suffix pointer read
//     and then a value read come between accept and select;
//   on the request that writes the last slot, a scan over the value memory
//     rebuilds the suffix minima, one slot per cycle, before the select.
// The single read port of the value memory sets the scan length.
// Results sit in an output register; a new request is taken while one waits.
// If the receiver stalls, the block holds its next result until the register
// frees. Reset clears pointers, fill state and the result valid flag.
`default_nettype none
module sliding_window_minimum import swm_pkg::*; #(
  parameter int WINDOW = 64
) (
  input  logic       clk,
  input  logic       rst,
  swm_in_if.sink     sample,
  swm_out_if.source  result
);

  cmd_t    cmd;
  status_t status;

  swm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .status       (status),
    .cmd          (cmd)
  );

  swm_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (sample.value),
    .result_ready (result.ready),
    .result_valid (result.valid),
    .min_value    (result.min_value),
    .min_slot     (result.min_slot),
    .first_return (result.first_return)
  );

endmodule
`default_nettype wire

// ===== src/swm_ctrl.sv =====
// Sequencing state machine for the sliding window minimum block.
`default_nettype none
module swm_ctrl import swm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.accept = 1'b1;
          if (!status.filled) begin
            state_next = ST_IDLE;
          end else if (status.last_slot) begin
            state_next = ST_SCAN;
          end else if (status.hit_old) begin
            state_next = ST_OM_PTR;
          end else begin
            state_next = ST_RESOLVE;
          end
        end
      end
      ST_OM_PTR: begin
        cmd.om_ptr = 1'b1;
        state_next = ST_OM_VAL;
      end
      ST_OM_VAL: begin
        cmd.om_val = 1'b1;
        state_next = ST_RESOLVE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = ST_LOAD;
      end
      ST_LOAD: begin
        if (!status.out_full) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/swm_datapath.sv =====
// Ring memories, stack pointers, rebuild scan and result register.
`default_nettype none
module swm_datapath import swm_pkg::*; #(
  parameter int WINDOW = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic [ValueW-1:0] value,
  input  logic              result_ready,
  output logic              result_valid,
  output logic [ValueW-1:0] min_value,
  output logic [SlotW-1:0]  min_slot,
  output logic              first_return
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IW-1:0] LastSlot = IW'(WINDOW - 1);
  localparam logic [IW-1:0] FillSlot = IW'(WINDOW - 2);

  // Ring storage, not reset; the fill phase writes slots 0 to WINDOW-2.
  logic [ValueW-1:0] val_mem  [WINDOW];
  logic [IW-1:0]     sfx_mem  [WINDOW];
  logic              flag_mem [WINDOW];

  logic [IW-1:0]     w, nm, om;
  logic [ValueW-1:0] nm_val, om_val;
  logic              filled;
  logic [IW-1:0]     best, rk, pk, res;
  logic [ValueW-1:0] best_val, res_val;
  logic              rlive, pv;
  logic [ValueW-1:0] val_rd;
  logic [IW-1:0]     sfx_rd;
  logic              flag_rd;

  logic              take;
  logic [IW-1:0]     best_next;
  logic [ValueW-1:0] best_val_next;
  logic              pick_old;
  logic [IW-1:0]     res_next;
  logic [ValueW-1:0] res_val_next;
  logic [IW-1:0]     val_raddr;

  assign take          = pv && (val_rd < best_val);
  assign best_next     = take ? pk : best;
  assign best_val_next = take ? val_rd : best_val;

  assign pick_old     = (w == '0) || !(nm_val < om_val);
  assign res_next     = pick_old ? om : nm;
  assign res_val_next = pick_old ? om_val : nm_val;

  assign val_raddr = cmd.scan ? rk : sfx_rd;

  assign status.filled    = filled;
  assign status.last_slot = (w == LastSlot);
  assign status.hit_old   = (w == om);
  assign status.scan_done = pv && (pk == '0);
  assign status.out_full  = result_valid && !result_ready;

  // Value memory: written per request, read by the scan and on pointer moves.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_mem[w] <= value;
    end
    if ((cmd.scan && rlive) || cmd.om_ptr) begin
      val_rd <= val_mem[val_raddr];
    end
  end

  // Suffix minimum pointers.
  always_ff @(posedge clk) begin
    if (cmd.accept && filled && (w == LastSlot)) begin
      sfx_mem[LastSlot] <= LastSlot;
    end else if (cmd.scan && pv) begin
      sfx_mem[pk] <= best_next;
    end
    if (cmd.accept) begin
      sfx_rd <= sfx_mem[w + IW'(1)];
    end
  end

  // Returned flags: cleared on write, set when returned.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flag_mem[w] <= 1'b0;
    end else if (cmd.load) begin
      flag_mem[res] <= 1'b1;
    end
    if (cmd.resolve) begin
      flag_rd <= flag_mem[res_next];
    end
  end

  // Pointer and fill control.
  always_ff @(posedge clk) begin
    if (rst) begin
      w      <= '0;
      nm     <= '0;
      om     <= '0;
      filled <= 1'b0;
      rlive  <= 1'b0;
      pv     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if ((w == '0) || (value < nm_val)) begin
          nm <= w;
        end
        if (!filled) begin
          w <= w + IW'(1);
          if (w == FillSlot) begin
            filled <= 1'b1;
          end
        end else if (w == LastSlot) begin
          w     <= '0;
          rlive <= 1'b1;
          pv    <= 1'b0;
        end else begin
          w <= w + IW'(1);
        end
      end
      if (cmd.om_ptr) begin
        om <= sfx_rd;
      end
      if (cmd.scan) begin
        pv <= rlive;
        if (rlive && (rk == '0)) begin
          rlive <= 1'b0;
        end
        if (status.scan_done) begin
          nm <= '0;
          om <= best_next;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if ((w == '0) || (value < nm_val)) begin
        nm_val <= value;
      end
      if (filled && (w == LastSlot)) begin
        best     <= LastSlot;
        best_val <= value;
        rk       <= FillSlot;
      end
    end
    if (cmd.om_val) begin
      om_val <= val_rd;
    end
    if (cmd.scan) begin
      pk       <= rk;
      best     <= best_next;
      best_val <= best_val_next;
      if (rlive && (rk != '0)) begin
        rk <= rk - IW'(1);
      end
      if (status.scan_done) begin
        om_val <= best_val_next;
      end
    end
    if (cmd.resolve) begin
      res     <= res_next;
      res_val <= res_val_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      min_value    <= res_val;
      min_slot     <= SlotW'(res);
      first_return <= !flag_rd;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sliding_window_minimum_tb.sv =====
`timescale 1ns / 1ps
// Testbench for sliding_window_minimum: directed and random value streams checked against a window model.
module sliding_window_minimum_tb;
  import swm_pkg::*;

  localparam int Window     = 64;
  localparam int StallLimit = 2000;
  localparam int PhaseItems = 445;
  localparam int NumPhases  = 4;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [SlotW-1:0]  slot;
    logic              first;
  } window_min_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  swm_in_if  sample_ch ();
  swm_out_if result_ch ();

  sliding_window_minimum #(.WINDOW(Window)) DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  // window model state
  logic [ValueW-1:0] ring_val   [Window];
  logic [SlotW-1:0]  suffix_ptr [Window];
  logic              returned   [Window];
  logic [SlotW-1:0]  wr_slot;
  logic [SlotW-1:0]  newest_min;
  logic [SlotW-1:0]  oldest_min;
  logic              primed;

  logic [ValueW-1:0] pending_values [$];
  window_min_t       expected_mins [$];
  window_min_t       oldest_exp;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int rebuilds       = 0;
  int departures     = 0;
  int idle_cycles    = 0;

  task automatic window_min_update(input logic [ValueW-1:0] v);
    logic [SlotW-1:0] w;
    logic [SlotW-1:0] nm;
    logic [SlotW-1:0] om;
    logic [SlotW-1:0] pick;
    window_min_t      e;
    w  = wr_slot;
    nm = newest_min;
    om = oldest_min;
    ring_val[w] = v;
    returned[w] = 1'b0;
    if (v < ring_val[nm]) nm = w;
    if (!primed) begin
      newest_min = nm;
      wr_slot    = w + 1'b1;
      if (int'(w) + 1 >= Window - 1) primed = 1'b1;
    end else begin
      if (int'(w) != Window - 1) begin
        // oldest minimum leaves the window: follow the suffix pointer
        if (w == om) begin
          om = suffix_ptr[int'(w) + 1];
          departures++;
        end
        wr_slot    = w + 1'b1;
        newest_min = nm;
        oldest_min = om;
        pick = (ring_val[nm] < ring_val[om]) ? nm : om;
      end else begin
        // last slot written: rebuild suffix minima, ties keep the higher slot
        pick = SlotW'(Window - 1);
        suffix_ptr[Window-1] = pick;
        for (int k = Window - 2; k >= 0; k--) begin
          if (ring_val[k] < ring_val[pick]) pick = SlotW'(k);
          suffix_ptr[k] = pick;
        end
        wr_slot    = '0;
        newest_min = '0;
        oldest_min = pick;
        rebuilds++;
      end
      e.value = ring_val[pick];
      e.slot  = pick;
      e.first = !returned[pick];
      returned[pick] = 1'b1;
      expected_mins.push_back(e);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      sample_ch.value <= '0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        window_min_update(sample_ch.value);
        requests_sent++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_ch.valid <= 1'b1;
          sample_ch.value <= pending_values.pop_front();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (expected_mins.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: min_value %h min_slot %0d first_return %0b",
                   $time, result_ch.min_value, result_ch.min_slot, result_ch.first_return);
        end else begin
          oldest_exp = expected_mins.pop_front();
          if (result_ch.min_value !== oldest_exp.value) begin
            errors++;
            $display("%0t: min_value expected %h actual %h",
                     $time, oldest_exp.value, result_ch.min_value);
          end
          if (result_ch.min_slot !== oldest_exp.slot) begin
            errors++;
            $display("%0t: min_slot expected %0d actual %0d",
                     $time, oldest_exp.slot, result_ch.min_slot);
          end
          if (result_ch.first_return !== oldest_exp.first) begin
            errors++;
            $display("%0t: first_return expected %0b actual %0b",
                     $time, oldest_exp.first, result_ch.first_return);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ValueW-1:0] directed [];
    int                total;
    int                run_len;
    int                mode;
    logic [ValueW-1:0] walk;
    logic [ValueW-1:0] v;
    directed = '{
      32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
      32'h0000_0003, 32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'h0000_0000,
      32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h0000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0002};
    sample_ch.valid = 1'b0;
    sample_ch.value = '0;
    result_ch.ready = 1'b0;
    for (int i = 0; i < Window; i++) begin
      ring_val[i]   = '0;
      suffix_ptr[i] = '0;
      returned[i]   = 1'b0;
    end
    wr_slot    = '0;
    newest_min = '0;
    oldest_min = '0;
    primed     = 1'b0;
    total      = 0;
    run_len    = 0;
    mode       = 0;
    walk       = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) pending_values.push_back(directed[i]);
    total += directed.size();

    // phases: no idling, idle sender, stalling receiver, light idling on both
    for (int phase = 0; phase < NumPhases; phase++) begin
      send_idle_pct  = (phase == 1) ? 74 : (phase == 3) ? 6 : 0;
      recv_stall_pct = (phase == 2) ? 74 : (phase == 3) ? 6 : 0;
      for (int i = 0; i < PhaseItems; i++) begin
        if (run_len == 0) begin
          run_len = $urandom_range(90, 1);
          mode    = $urandom_range(4);
          walk    = $urandom;
        end
        case (mode)
          0: v = $urandom;
          1: v = $urandom_range(3);
          2: begin
            walk = walk - $urandom_range(3);
            v    = walk;
          end
          3: begin
            walk = walk + $urandom_range(3);
            v    = walk;
          end
          default: v = walk;
        endcase
        pending_values.push_back(v);
        run_len--;
      end
      total += PhaseItems;
      while (requests_sent != total) @(posedge clk);
    end

    while (expected_mins.size() != 0) @(posedge clk);
    repeat (Window + 8) @(posedge clk);
    errors += expected_mins.size();

    $display("Covered %0d requests, %0d results, %0d rebuild passes, %0d oldest-minimum exits",
             requests_sent, results_seen, rebuilds, departures);
    $display("across four idling phases; %0d mismatches", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/swm_pkg.sv
src/swm_if.sv
src/swm_ctrl.sv
src/swm_datapath.sv
src/sliding_window_minimum.sv
tb/sliding_window_minimum_tb.sv
